@@ rtl/sags_pkg.sv @@
// Package for the sector antenna gain select block: widths, payload types, tables.
`default_nettype none

package sags_pkg;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned ANGLE_BITS   = 16;
  localparam int unsigned GAIN_BITS    = 16;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam int unsigned GUARD_SHIFT  = 20;
  localparam int unsigned XY_BITS_DEF  = COORD_BITS + GUARD_SHIFT + 4;
  localparam int unsigned Z_BITS       = 32;
  localparam int unsigned CORDIC_ITERS = (ANGLE_BITS + 4 < 32) ? ANGLE_BITS + 4 : 32;

  localparam logic [Z_BITS-1:0] Z_HALF    = Z_BITS'(1) << (Z_BITS - 1);
  localparam logic [Z_BITS-1:0] ROUND_INC = Z_BITS'(1) << (Z_BITS - 1 - ANGLE_BITS);

  localparam logic [ANGLE_BITS-1:0] BEAM_DIR_RST   = ANGLE_BITS'(0);
  localparam logic [ANGLE_BITS-1:0] HALF_WIDTH_RST = ANGLE_BITS'(32768);
  localparam logic [GAIN_BITS-1:0]  GAIN_IN_RST    = GAIN_BITS'(256);
  localparam logic [GAIN_BITS-1:0]  GAIN_OUT_RST   = GAIN_BITS'(0);

  localparam logic [CFG_IDX_BITS-1:0] REG_BEAM_DIR    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TX_GAIN_IN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TX_GAIN_OUT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RX_GAIN_IN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RX_GAIN_OUT = 3'd5;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] delta_x;
    logic signed [COORD_BITS-1:0] delta_y;
  } sags_in_t;

  typedef struct packed {
    logic                  in_sector;
    logic [ANGLE_BITS-1:0] bearing;
    logic [GAIN_BITS-1:0]  tx_gain;
    logic [GAIN_BITS-1:0]  rx_gain;
  } sags_out_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } sags_ctl_t;

  function automatic logic [Z_BITS-1:0] atan_step(input int unsigned i);
    case (i)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      24: return 32'd41;
      25: return 32'd20;
      26: return 32'd10;
      27: return 32'd5;
      28: return 32'd3;
      29: return 32'd1;
      30: return 32'd1;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/sags_cordic_stage.sv @@
// One CORDIC vectoring rotation with its pipeline register.
`default_nettype none

module sags_cordic_stage #(
  parameter int unsigned XY_BITS = sags_pkg::XY_BITS_DEF,
  parameter int unsigned ITER    = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  sags_pkg::sags_ctl_t               ctl_in,
  input  logic signed [XY_BITS-1:0]         x_in,
  input  logic signed [XY_BITS-1:0]         y_in,
  input  logic [sags_pkg::Z_BITS-1:0]       z_in,
  output sags_pkg::sags_ctl_t               ctl_out,
  output logic signed [XY_BITS-1:0]         x_out,
  output logic signed [XY_BITS-1:0]         y_out,
  output logic [sags_pkg::Z_BITS-1:0]       z_out
);
  import sags_pkg::*;

  localparam logic [Z_BITS-1:0] STEP_ANGLE = atan_step(ITER);

  sags_ctl_t                 ctl_r;
  logic signed [XY_BITS-1:0] x_r;
  logic signed [XY_BITS-1:0] y_r;
  logic [Z_BITS-1:0]         z_r;
  logic signed [XY_BITS-1:0] x_nxt;
  logic signed [XY_BITS-1:0] y_nxt;
  logic [Z_BITS-1:0]         z_nxt;
  logic signed [XY_BITS-1:0] xs;
  logic signed [XY_BITS-1:0] ys;

  always_comb begin
    xs = x_in >>> ITER;
    ys = y_in >>> ITER;
    if (!y_in[XY_BITS-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + STEP_ANGLE;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

`default_nettype wire

@@ rtl/sector_antenna_gain_select.sv @@
// Sector antenna gain select: CORDIC bearing of (delta_x, delta_y), sector test, gain pick.
// Input to result passes the input, CORDIC rotation, rounding and output stage registers.
// Throughput: one transaction per cycle unless stalled; one CORDIC rotation per pipeline stage.
// Stalls hold only the occupied stages, so bubbles close up while the result waits.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
`default_nettype none

module sector_antenna_gain_select #(
  parameter int unsigned XY_BITS = sags_pkg::XY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sags_pkg::sags_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sags_pkg::sags_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sags_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sags_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import sags_pkg::*;

  localparam int unsigned N    = CORDIC_ITERS;
  localparam int unsigned RND  = N + 1;
  localparam int unsigned OUTS = N + 2;

  logic [ANGLE_BITS-1:0] dir_r;
  logic [ANGLE_BITS-1:0] hw_r;
  logic [GAIN_BITS-1:0]  tx_in_r;
  logic [GAIN_BITS-1:0]  tx_out_r;
  logic [GAIN_BITS-1:0]  rx_in_r;
  logic [GAIN_BITS-1:0]  rx_out_r;
  logic [ANGLE_BITS-1:0] lo_r;
  logic [ANGLE_BITS-1:0] hi_r;
  logic [ANGLE_BITS-1:0] cfg_angle;
  logic [GAIN_BITS-1:0]  cfg_gain;

  logic [OUTS:0] ena;
  logic [OUTS:0] vld;

  logic signed [XY_BITS-1:0] x_s [0:N];
  logic signed [XY_BITS-1:0] y_s [0:N];
  logic [Z_BITS-1:0]         z_s [0:N];
  sags_ctl_t                 c_s [0:N];

  sags_ctl_t                 c0_r;
  sags_ctl_t                 c0_nxt;
  logic signed [XY_BITS-1:0] x0_r;
  logic signed [XY_BITS-1:0] y0_r;
  logic [Z_BITS-1:0]         z0_r;
  logic signed [XY_BITS-1:0] x0_nxt;
  logic signed [XY_BITS-1:0] y0_nxt;
  logic [Z_BITS-1:0]         z0_nxt;
  logic signed [XY_BITS-1:0] x_sc;
  logic signed [XY_BITS-1:0] y_sc;

  logic                  rnd_v_r;
  logic [ANGLE_BITS-1:0] bearing_r;
  logic [ANGLE_BITS-1:0] bearing_nxt;
  logic [Z_BITS-1:0]     z_round;

  logic                  out_valid_r;
  sags_out_t             out_r;
  sags_out_t             out_nxt;
  logic                  hit;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_angle = ANGLE_BITS'(cfg_data);
  assign cfg_gain  = GAIN_BITS'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= BEAM_DIR_RST;
      hw_r     <= HALF_WIDTH_RST;
      tx_in_r  <= GAIN_IN_RST;
      tx_out_r <= GAIN_OUT_RST;
      rx_in_r  <= GAIN_IN_RST;
      rx_out_r <= GAIN_OUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BEAM_DIR:    dir_r    <= cfg_angle;
        REG_HALF_WIDTH:  hw_r     <= cfg_angle;
        REG_TX_GAIN_IN:  tx_in_r  <= cfg_gain;
        REG_TX_GAIN_OUT: tx_out_r <= cfg_gain;
        REG_RX_GAIN_IN:  rx_in_r  <= cfg_gain;
        REG_RX_GAIN_OUT: rx_out_r <= cfg_gain;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= dir_r - hw_r;
    hi_r <= dir_r + hw_r;
  end

  // Stage enables: advance when empty or when the next stage advances
  genvar k;
  generate
    for (k = 0; k <= N; k++) begin : g_vld
      assign vld[k] = c_s[k].valid;
    end
    for (k = 0; k < OUTS; k++) begin : g_ena
      assign ena[k] = !vld[k] || ena[k+1];
    end
  endgenerate

  assign vld[RND]  = rnd_v_r;
  assign vld[OUTS] = out_valid_r;
  assign ena[OUTS] = !out_valid_r || out_ready;
  assign in_ready  = ena[0];

  // Input stage: scale, fold into the right half-plane
  always_comb begin
    x_sc = {{(XY_BITS-COORD_BITS){in_data.delta_x[COORD_BITS-1]}}, in_data.delta_x};
    y_sc = {{(XY_BITS-COORD_BITS){in_data.delta_y[COORD_BITS-1]}}, in_data.delta_y};
    x_sc = x_sc <<< GUARD_SHIFT;
    y_sc = y_sc <<< GUARD_SHIFT;
    c0_nxt.valid = in_valid;
    c0_nxt.zero  = (in_data.delta_x == '0) && (in_data.delta_y == '0);
    if (x_sc[XY_BITS-1]) begin
      x0_nxt = -x_sc;
      y0_nxt = -y_sc;
      z0_nxt = Z_HALF;
    end else begin
      x0_nxt = x_sc;
      y0_nxt = y_sc;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (ena[0]) begin
      c0_r <= c0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ena[0]) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
      z0_r <= z0_nxt;
    end
  end

  assign c_s[0] = c0_r;
  assign x_s[0] = x0_r;
  assign y_s[0] = y0_r;
  assign z_s[0] = z0_r;

  generate
    for (k = 1; k <= N; k++) begin : g_cordic
      sags_cordic_stage #(
        .XY_BITS (XY_BITS),
        .ITER    (k - 1)
      ) u_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (ena[k]),
        .ctl_in  (c_s[k-1]),
        .x_in    (x_s[k-1]),
        .y_in    (y_s[k-1]),
        .z_in    (z_s[k-1]),
        .ctl_out (c_s[k]),
        .x_out   (x_s[k]),
        .y_out   (y_s[k]),
        .z_out   (z_s[k])
      );
    end
  endgenerate

  // Rounding stage
  always_comb begin
    z_round     = z_s[N] + ROUND_INC;
    bearing_nxt = c_s[N].zero ? '0 : z_round[Z_BITS-1 -: ANGLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else if (ena[RND]) begin
      rnd_v_r <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (ena[RND]) begin
      bearing_r <= bearing_nxt;
    end
  end

  // Sector test and gain select
  always_comb begin
    if (lo_r == hi_r) begin
      hit = 1'b1;
    end else if (lo_r < hi_r) begin
      hit = (lo_r <= bearing_r) && (bearing_r <= hi_r);
    end else begin
      hit = !((hi_r <= bearing_r) && (bearing_r <= lo_r));
    end
    out_nxt.in_sector = hit;
    out_nxt.bearing   = bearing_r;
    out_nxt.tx_gain   = hit ? tx_in_r : tx_out_r;
    out_nxt.rx_gain   = hit ? rx_in_r : rx_out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ena[OUTS]) begin
      out_valid_r <= rnd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena[OUTS]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with output stage empty");

  a_round_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_v_r && !ena[RND] |=> rnd_v_r && $stable(bearing_r))
    else $error("stalled rounding stage lost its transaction");

  a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
    c0_r.valid && !ena[0] |=> c0_r.valid && $stable(x0_r) && $stable(z0_r))
    else $error("stalled input stage lost its transaction");
`endif

endmodule

`default_nettype wire

@@ tb/sector_antenna_gain_select_tb.sv @@
// Testbench for sector_antenna_gain_select: directed table, randomised vectors, bearing predictor.
`timescale 1ns / 1ps

module sector_antenna_gain_select_tb;
  import sags_pkg::*;

  localparam int RANDOM_BLOCKS   = 4;
  localparam int ITEMS_PER_BLOCK = 104;
  localparam int LONG_HOLD       = 200;
  localparam int HOLD_AT         = 876;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam int DRAIN_CYCLES    = CORDIC_ITERS + 8;
  localparam int ROTATIONS       = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int SENDER_IDLE   [3] = '{28, 52, 0};
  localparam int RECEIVER_IDLE [3] = '{52, 28, 0};

  localparam logic [31:0] ATAN_TURNS [ROTATIONS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] value;
    sags_in_t                 vec;
    sags_out_t                result;
  } stim_row_t;

  localparam sags_out_t NONE = '0;
  localparam sags_in_t  NOVEC = '0;

  localparam int DIRECTED_ROWS = 37;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b1, 16'h0000, 16'h0100, 16'h0100}},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, -16'sd5},   '{1'b1, 16'hC000, 16'h0100, 16'h0100}},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh8000}, '{1'b1, 16'hC000, 16'h0100, 16'h0100}},
    '{ROW_PREDICT, '0, '0, '{16'sh7FFF, 16'sh0000}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sh8000, 16'sh0000}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sh0000, 16'sh7FFF}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sh8000, 16'sh8000}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sh7FFF, 16'sh7FFF}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'shFFFF, 16'shFFFF}, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sh0001, 16'sh8000}, NONE},
    '{ROW_WRITE, REG_TX_GAIN_IN,  16'hFFFF, NOVEC, NONE},
    '{ROW_WRITE, REG_TX_GAIN_OUT, 16'h0000, NOVEC, NONE},
    '{ROW_WRITE, REG_RX_GAIN_IN,  16'h0000, NOVEC, NONE},
    '{ROW_WRITE, REG_RX_GAIN_OUT, 16'hFFFF, NOVEC, NONE},
    '{ROW_WRITE, REG_HALF_WIDTH,  16'h0000, NOVEC, NONE},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b1, 16'h0000, 16'hFFFF, 16'h0000}},
    '{ROW_PREDICT, '0, '0, '{16'sh8000, 16'sd5},    NONE},
    '{ROW_WRITE, REG_BEAM_DIR,    16'h4000, NOVEC, NONE},
    '{ROW_WRITE, REG_HALF_WIDTH,  16'h2000, NOVEC, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sd0, 16'sd100},     NONE},
    '{ROW_PREDICT, '0, '0, '{16'sd100, 16'sd0},     NONE},
    '{ROW_TYPED,   '0, '0, '{16'sd0, -16'sd100},    '{1'b0, 16'hC000, 16'h0000, 16'hFFFF}},
    '{ROW_WRITE, REG_BEAM_DIR,    16'h0000, NOVEC, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sd100, 16'sd0},     NONE},
    '{ROW_PREDICT, '0, '0, '{16'sd100, -16'sd10},   NONE},
    '{ROW_PREDICT, '0, '0, '{-16'sd100, 16'sd0},    NONE},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b1, 16'h0000, 16'hFFFF, 16'h0000}},
    '{ROW_WRITE, REG_HALF_WIDTH,  16'h9C40, NOVEC, NONE},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b0, 16'h0000, 16'h0000, 16'hFFFF}},
    '{ROW_PREDICT, '0, '0, '{-16'sd100, 16'sd0},    NONE},
    '{ROW_WRITE, REG_BEAM_DIR,    16'hFFFF, NOVEC, NONE},
    '{ROW_WRITE, REG_HALF_WIDTH,  16'hFFFF, NOVEC, NONE},
    '{ROW_PREDICT, '0, '0, '{16'sd100, -16'sd1},    NONE},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b1, 16'h0000, 16'hFFFF, 16'h0000}},
    '{ROW_WRITE, REG_SPARE_LO,    16'hFFFF, NOVEC, NONE},
    '{ROW_WRITE, REG_SPARE_HI,    16'h1234, NOVEC, NONE},
    '{ROW_TYPED,   '0, '0, '{16'sh0000, 16'sh0000}, '{1'b1, 16'h0000, 16'hFFFF, 16'h0000}}
  };

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  sags_in_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  sags_out_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

  sags_out_t                expected_results [$];
  logic [CFG_DATA_BITS-1:0] reg_shadow [6];
  int                       tx_idle_pct = 0;
  int                       rx_idle_pct = 0;
  int                       mismatches = 0;
  int                       stall_cycles = 0;
  int                       in_taken = 0;
  int                       hold_left = 0;
  bit                       held_once = 1'b0;

  sector_antenna_gain_select uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [ANGLE_BITS-1:0] cordic_bearing(sags_in_t v);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    logic [32:0] rounded;
    if (v.delta_x == 0 && v.delta_y == 0) return '0;
    x = longint'(v.delta_x) * 64'sd1048576;
    y = longint'(v.delta_y) * 64'sd1048576;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TURNS[i];
      end
    end
    rounded = {1'b0, z} + 33'd32768;
    return rounded[31:16];
  endfunction

  function automatic sags_out_t select_gains(sags_in_t v);
    sags_out_t             r;
    logic [ANGLE_BITS-1:0] lo;
    logic [ANGLE_BITS-1:0] hi;
    r.bearing = cordic_bearing(v);
    lo = reg_shadow[REG_BEAM_DIR] - reg_shadow[REG_HALF_WIDTH];
    hi = reg_shadow[REG_BEAM_DIR] + reg_shadow[REG_HALF_WIDTH];
    if (lo == hi) r.in_sector = 1'b1;
    else if (lo < hi) r.in_sector = (r.bearing >= lo) && (r.bearing <= hi);
    else r.in_sector = !((r.bearing >= hi) && (r.bearing <= lo));
    r.tx_gain = r.in_sector ? reg_shadow[REG_TX_GAIN_IN] : reg_shadow[REG_TX_GAIN_OUT];
    r.rx_gain = r.in_sector ? reg_shadow[REG_RX_GAIN_IN] : reg_shadow[REG_RX_GAIN_OUT];
    return r;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_setting();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'($urandom_range(2048));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sags_in_t pick_vector();
    sags_in_t           v;
    logic signed [15:0] edges [5];
    edges = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};
    case ($urandom_range(9))
      0: begin
        v.delta_x = '0;
        v.delta_y = 16'($urandom);
      end
      1: begin
        v.delta_x = 16'($urandom);
        v.delta_y = '0;
      end
      2: begin
        v.delta_x = edges[$urandom_range(4)];
        v.delta_y = edges[$urandom_range(4)];
      end
      3: begin
        v.delta_x = 16'($urandom_range(64)) - 16'd32;
        v.delta_y = 16'($urandom_range(64)) - 16'd32;
      end
      default: begin
        v.delta_x = 16'($urandom);
        v.delta_y = 16'($urandom);
      end
    endcase
    return v;
  endfunction

  task automatic load_register(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_RX_GAIN_OUT) reg_shadow[idx] = value;
  endtask

  task automatic offer_vector(input sags_in_t v, input bit typed, input sags_out_t typed_result);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(typed ? typed_result : select_gains(v));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) in_taken++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held_once && in_taken >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sags_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: in_sector=%0b bearing=%h tx=%h rx=%h",
                   out_data.in_sector, out_data.bearing, out_data.tx_gain, out_data.rx_gain);
      end else begin
        want = expected_results.pop_front();
        if (out_data.in_sector !== want.in_sector || out_data.bearing !== want.bearing ||
            out_data.tx_gain !== want.tx_gain || out_data.rx_gain !== want.rx_gain) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected in_sector=%0b bearing=%h tx=%h rx=%h, got %0b %h %h %h",
                     want.in_sector, want.bearing, want.tx_gain, want.rx_gain,
                     out_data.in_sector, out_data.bearing, out_data.tx_gain, out_data.rx_gain);
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sector_antenna_gain_select verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    row_kind_t prev_kind;
    prev_kind = ROW_PREDICT;
    reg_shadow = '{BEAM_DIR_RST, HALF_WIDTH_RST, GAIN_IN_RST, GAIN_OUT_RST,
                   GAIN_IN_RST, GAIN_OUT_RST};
    tx_idle_pct = SENDER_IDLE[0];
    rx_idle_pct = RECEIVER_IDLE[0];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        if (prev_kind != ROW_WRITE) settle();
        load_register(DIRECTED[r].index, DIRECTED[r].value);
      end else begin
        if (prev_kind == ROW_WRITE) cfg_valid <= 1'b0;
        offer_vector(DIRECTED[r].vec, DIRECTED[r].kind == ROW_TYPED, DIRECTED[r].result);
      end
      prev_kind = DIRECTED[r].kind;
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = SENDER_IDLE[phase];
      rx_idle_pct = RECEIVER_IDLE[phase];
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
        settle();
        for (int idx = REG_BEAM_DIR; idx <= REG_RX_GAIN_OUT; idx++)
          load_register(CFG_IDX_BITS'(idx), pick_setting());
        if ($urandom_range(3) == 0)
          load_register($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
        cfg_valid <= 1'b0;
        for (int n = 0; n < ITEMS_PER_BLOCK; n++)
          offer_vector(pick_vector(), 1'b0, NONE);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("sector_antenna_gain_select verification clean");
    else
      $display("sector_antenna_gain_select verification failed");
    $finish;
  end

endmodule

@@ sector_antenna_gain_select.f @@
rtl/sags_pkg.sv
rtl/sags_cordic_stage.sv
rtl/sector_antenna_gain_select.sv
tb/sector_antenna_gain_select_tb.sv
